@@ sv/sass_pkg.sv @@
// Shared types and codes for the small array sort and search unit.
// No dependencies; used by sass_cmp and small_array_sort_and_search_unit.
package sass_pkg;

    localparam int DataW  = 32;
    localparam int IndexW = 4;
    localparam int MaxDisp = 16;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SORT = 2'd1,
        OP_SEEK = 2'd2,
        OP_DISP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_LI,
        S_SORT_CMP,
        S_SORT_WB,
        S_SEEK,
        S_DISP,
        S_RESP
    } t_state;

    // Result of the shared comparator.
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

endpackage

@@ sv/sass_cmp.sv @@
// Shared signed comparator: greater-than and equality of two 32-bit words.
// Depends on sass_pkg.
module sass_cmp (
    input  logic signed [sass_pkg::DataW-1:0] i_a,
    input  logic signed [sass_pkg::DataW-1:0] i_b,
    output sass_pkg::t_cmp                    o_res
);

    assign o_res.gt = (i_a > i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

@@ sv/small_array_sort_and_search_unit.sv @@
// Top level of the small array sort and search unit: sequencer, element store,
// output register. Depends on sass_pkg and sass_cmp.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command per transfer:
//   load (append i_value, i_start_new empties the store first), sort
//   (ascending exchange sort), seek (first index equal to i_value) and
//   display (every element in order, up to sixteen, last one flagged).
//   Output channel (o_valid / i_ready) returns results through a single
//   output register; o_last marks the final result of each command.
//   o_ready is high only while the sequencer is idle: one command at a time.
// Command flow (n = element count):
//   load and empty-store commands: the result passes through the response
//   state into the output register, and o_ready returns as it becomes valid.
//   seek: one comparison per cycle through the shared comparator fed by the
//   registered read port of the store.
//   sort: n(n-1)/2 comparisons at one per cycle; each outer pass also loads
//   the pivot entry and writes it back.
//   display: one result per cycle while the receiver takes them.
// Reset: synchronous active low; clears the count and the sequencer. Store
//   contents are not cleared (only entries below the count are ever read).
// Stall: a held result parks in the output register; display simply waits
//   with the read address held, nothing is dropped.
module small_array_sort_and_search_unit #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_operation,
    input  logic signed [sass_pkg::DataW-1:0] i_value,
    input  logic                              i_start_new,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [sass_pkg::DataW-1:0] o_result_value,
    output logic [sass_pkg::IndexW-1:0]       o_result_index,
    output logic                              o_found,
    output logic                              o_last,
    output logic [1:0]                        o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DispN = (DEPTH < sass_pkg::MaxDisp) ? DEPTH : sass_pkg::MaxDisp;
    localparam logic [CW-1:0] DepthC = CW'(DEPTH);
    localparam logic [CW-1:0] DispC  = CW'(DispN);

    // element store: one write port, one registered read port
    logic signed [sass_pkg::DataW-1:0] r_mem [DEPTH];
    logic signed [sass_pkg::DataW-1:0] r_rd_data;
    logic [AW-1:0]                     w_rd_addr;
    logic                              w_wr_en;
    logic [AW-1:0]                     w_wr_addr;
    logic signed [sass_pkg::DataW-1:0] w_wr_data;

    // sequencer state
    sass_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic signed [sass_pkg::DataW-1:0] r_cur, n_cur;   // pivot for sort, key for seek

    // pending single result
    logic [sass_pkg::IndexW-1:0] r_pend_index, n_pend_index;
    logic                        r_pend_found, n_pend_found;
    sass_pkg::t_status           r_pend_status, n_pend_status;

    // output register
    logic                              r_out_valid;
    logic signed [sass_pkg::DataW-1:0] r_out_value;
    logic [sass_pkg::IndexW-1:0]       r_out_index;
    logic                              r_out_found;
    logic                              r_out_last;
    sass_pkg::t_status                 r_out_status;

    logic                              w_out_free;
    logic                              w_emit;
    logic signed [sass_pkg::DataW-1:0] w_emit_value;
    logic [sass_pkg::IndexW-1:0]       w_emit_index;
    logic                              w_emit_found;
    logic                              w_emit_last;
    sass_pkg::t_status                 w_emit_status;

    sass_pkg::t_cmp w_cmp;
    logic [CW-1:0]  w_disp_n;

    sass_cmp u_cmp (
        .i_a   (r_cur),
        .i_b   (r_rd_data),
        .o_res (w_cmp)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_disp_n   = (r_count > DispC) ? DispC : r_count;
    assign o_ready    = (r_state == sass_pkg::S_IDLE);

    // sequencer: next state and datapath controls
    always_comb begin
        logic [CW-1:0] n0;
        n0            = i_start_new ? '0 : r_count;
        n_state       = r_state;
        n_count       = r_count;
        n_i           = r_i;
        n_j           = r_j;
        n_cur         = r_cur;
        n_pend_index  = r_pend_index;
        n_pend_found  = r_pend_found;
        n_pend_status = r_pend_status;
        w_rd_addr     = r_i[AW-1:0];
        w_wr_en       = 1'b0;
        w_wr_addr     = r_j[AW-1:0];
        w_wr_data     = r_cur;
        w_emit        = 1'b0;
        w_emit_value  = '0;
        w_emit_index  = '0;
        w_emit_found  = 1'b0;
        w_emit_last   = 1'b1;
        w_emit_status = r_pend_status;

        unique case (r_state)
            sass_pkg::S_IDLE: begin
                w_rd_addr     = '0;
                n_i           = '0;
                n_pend_index  = '0;
                n_pend_found  = 1'b0;
                n_pend_status = sass_pkg::ST_OK;
                if (i_valid) begin
                    unique case (sass_pkg::t_op'(i_operation))
                        sass_pkg::OP_LOAD: begin
                            n_state = sass_pkg::S_RESP;
                            if (n0 == DepthC) begin
                                n_count       = n0;
                                n_pend_status = sass_pkg::ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = n0[AW-1:0];
                                w_wr_data = i_value;
                                n_count   = n0 + 1'b1;
                            end
                        end
                        sass_pkg::OP_SORT: begin
                            if (r_count < CW'(2)) begin
                                n_state = sass_pkg::S_RESP;
                                if (r_count == '0) n_pend_status = sass_pkg::ST_EMPTY;
                            end else begin
                                n_state = sass_pkg::S_SORT_LI;
                            end
                        end
                        sass_pkg::OP_SEEK: begin
                            n_cur = i_value;
                            if (r_count == '0) begin
                                n_state       = sass_pkg::S_RESP;
                                n_pend_status = sass_pkg::ST_EMPTY;
                            end else begin
                                n_state = sass_pkg::S_SEEK;
                            end
                        end
                        sass_pkg::OP_DISP: begin
                            if (r_count == '0) begin
                                n_state       = sass_pkg::S_RESP;
                                n_pend_status = sass_pkg::ST_EMPTY;
                            end else begin
                                n_state = sass_pkg::S_DISP;
                            end
                        end
                        default: n_state = sass_pkg::S_RESP;
                    endcase
                end
            end
            sass_pkg::S_SORT_LI: begin
                // pivot entry arrives; start inner pass at i+1
                n_cur     = r_rd_data;
                n_j       = r_i + 1'b1;
                w_rd_addr = n_j[AW-1:0];
                n_state   = sass_pkg::S_SORT_CMP;
            end
            sass_pkg::S_SORT_CMP: begin
                if (w_cmp.gt) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_j[AW-1:0];
                    w_wr_data = r_cur;
                    n_cur     = r_rd_data;
                end
                if ((r_j + 1'b1) < r_count) begin
                    n_j       = r_j + 1'b1;
                    w_rd_addr = n_j[AW-1:0];
                end else begin
                    n_state = sass_pkg::S_SORT_WB;
                end
            end
            sass_pkg::S_SORT_WB: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_i[AW-1:0];
                w_wr_data = r_cur;
                if ((r_i + 1'b1) < (r_count - 1'b1)) begin
                    n_i       = r_i + 1'b1;
                    w_rd_addr = n_i[AW-1:0];
                    n_state   = sass_pkg::S_SORT_LI;
                end else begin
                    n_state = sass_pkg::S_RESP;
                end
            end
            sass_pkg::S_SEEK: begin
                if (w_cmp.eq) begin
                    n_pend_index = sass_pkg::IndexW'(r_i);
                    n_pend_found = 1'b1;
                    n_state      = sass_pkg::S_RESP;
                end else if ((r_i + 1'b1) < r_count) begin
                    n_i       = r_i + 1'b1;
                    w_rd_addr = n_i[AW-1:0];
                end else begin
                    n_state = sass_pkg::S_RESP;
                end
            end
            sass_pkg::S_DISP: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_value  = r_rd_data;
                    w_emit_index  = sass_pkg::IndexW'(r_i);
                    w_emit_last   = ((r_i + 1'b1) == w_disp_n);
                    w_emit_status = sass_pkg::ST_OK;
                    if (w_emit_last) begin
                        n_state = sass_pkg::S_IDLE;
                    end else begin
                        n_i       = r_i + 1'b1;
                        w_rd_addr = n_i[AW-1:0];
                    end
                end
            end
            sass_pkg::S_RESP: begin
                if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_emit_index = r_pend_index;
                    w_emit_found = r_pend_found;
                    n_state      = sass_pkg::S_IDLE;
                end
            end
            default: n_state = sass_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sass_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i           <= n_i;
        r_j           <= n_j;
        r_cur         <= n_cur;
        r_pend_index  <= n_pend_index;
        r_pend_found  <= n_pend_found;
        r_pend_status <= n_pend_status;
    end

    // store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rd_data <= r_mem[w_rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_index  <= w_emit_index;
            r_out_found  <= w_emit_found;
            r_out_last   <= w_emit_last;
            r_out_status <= w_emit_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_index = r_out_index;
    assign o_found        = r_out_found;
    assign o_last         = r_out_last;
    assign o_status       = r_out_status;

    // count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthC)
        else $error("element count above depth");

    // inner sort index always lies beyond the pivot
    a_sort_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sass_pkg::S_SORT_CMP) |-> (r_j > r_i))
        else $error("sort inner index not beyond pivot");

    // seek and display never modify the store
    a_no_write_read_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sass_pkg::S_SEEK || r_state == sass_pkg::S_DISP) |-> !w_wr_en)
        else $error("store written during seek or display");

    // every accepted command leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != sass_pkg::S_IDLE))
        else $error("accepted command did not start");

endmodule
